// ===== rtl/assert_macros.svh =====
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbq_pkg.sv =====
package sbq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int HIST_BITS      = SAMPLE_BITS + 1;
    localparam int PROD_BITS      = COEF_BITS + HIST_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int NUM_COEF       = 5;
    localparam int NUM_CHAN       = 2;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic signed [HIST_BITS-1:0] HIST_ONE =
        HIST_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } coef_idx_t;

    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [HIST_BITS-1:0]   hist_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    // One direct form I step: full-precision sum, round half up, saturate.
    function automatic sample_t biquad_step(
        input coef_set_t c,
        input sample_t   x0,
        input hist_t     x1,
        input hist_t     x2,
        input hist_t     y1,
        input hist_t     y2
    );
        logic signed [HIST_BITS-1:0] x0_ext;
        logic signed [PROD_BITS-1:0] p_b0;
        logic signed [PROD_BITS-1:0] p_b1;
        logic signed [PROD_BITS-1:0] p_b2;
        logic signed [PROD_BITS-1:0] p_a1;
        logic signed [PROD_BITS-1:0] p_a2;
        logic signed [ACC_BITS-1:0]  acc;
        logic signed [ACC_BITS-1:0]  shifted;
        sample_t                     res;
        x0_ext  = HIST_BITS'(x0);
        p_b0    = c.b0 * x0_ext;
        p_b1    = c.b1 * x1;
        p_b2    = c.b2 * x2;
        p_a1    = c.a1 * y1;
        p_a2    = c.a2 * y2;
        acc     = ACC_BITS'(p_b0) + ACC_BITS'(p_b1) + ACC_BITS'(p_b2)
                - ACC_BITS'(p_a1) - ACC_BITS'(p_a2) + ROUND_HALF;
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > SAT_MAX) begin
            res = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_MIN) begin
            res = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else begin
            res = shifted[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/stereo_biquad_filter.sv =====
// Stereo biquad filter, direct form I, five shared Q2.30 coefficients.
// Input channel: in_valid / in_stall with left_in and right_in (Q1.23).
// Output channel: out_valid / out_stall with left_out and right_out (Q1.23),
// rounded half up and saturated to 24 bits; one result per input frame.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 b0, 1 b1, 2 b2,
// 3 a1, 4 a2) and cfg_data; cfg_ready is always high, other indexes are
// dropped. Write coefficients only while no frame is in flight.
// Path: a transferred frame is captured in the input register and moves to the
// output register when advance is high. Throughput: one frame per cycle unless
// stalled; the two channels' ten multiplies, sum and saturation are combinational
// between the input and output registers, closing the feedback loop there.
// Reset: coefficients clear to zero, all input and output history entries
// load 1.0, both valids drop.
// Stall: the output register holds; one more frame is taken into the input
// register, after which in_stall follows out_stall until the output drains.
module stereo_biquad_filter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [sbq_pkg::SAMPLE_BITS-1:0]   left_in,
    input  logic signed [sbq_pkg::SAMPLE_BITS-1:0]   right_in,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [sbq_pkg::SAMPLE_BITS-1:0]   left_out,
    output logic signed [sbq_pkg::SAMPLE_BITS-1:0]   right_out,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [sbq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic        [sbq_pkg::COEF_BITS-1:0]     cfg_data
);

    `include "assert_macros.svh"

    sbq_pkg::coef_set_t coef_reg;
    logic               in_valid_reg;
    sbq_pkg::sample_t   in_sample_reg  [sbq_pkg::NUM_CHAN];
    sbq_pkg::hist_t     x1_reg         [sbq_pkg::NUM_CHAN];
    sbq_pkg::hist_t     x2_reg         [sbq_pkg::NUM_CHAN];
    sbq_pkg::hist_t     y1_reg         [sbq_pkg::NUM_CHAN];
    sbq_pkg::hist_t     y2_reg         [sbq_pkg::NUM_CHAN];
    logic               out_valid_reg;
    sbq_pkg::sample_t   out_sample_reg [sbq_pkg::NUM_CHAN];
    sbq_pkg::sample_t   y_next         [sbq_pkg::NUM_CHAN];
    logic               advance;
    logic               in_xfer;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign left_out  = out_sample_reg[0];
    assign right_out = out_sample_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbq_pkg::REG_B0: coef_reg.b0 <= cfg_data;
                sbq_pkg::REG_B1: coef_reg.b1 <= cfg_data;
                sbq_pkg::REG_B2: coef_reg.b2 <= cfg_data;
                sbq_pkg::REG_A1: coef_reg.a1 <= cfg_data;
                sbq_pkg::REG_A2: coef_reg.a2 <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < sbq_pkg::NUM_CHAN; ch++)
        begin
            y_next[ch] = sbq_pkg::biquad_step(coef_reg, in_sample_reg[ch],
                                              x1_reg[ch], x2_reg[ch],
                                              y1_reg[ch], y2_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < sbq_pkg::NUM_CHAN; ch++)
        begin
            if (in_xfer)
            begin
                in_sample_reg[ch] <= (ch == 0) ? left_in : right_in;
            end
            if (advance)
            begin
                out_sample_reg[ch] <= y_next[ch];
            end
        end
    end

    // History: advance on every frame that moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < sbq_pkg::NUM_CHAN; ch++)
            begin
                x1_reg[ch] <= sbq_pkg::HIST_ONE;
                x2_reg[ch] <= sbq_pkg::HIST_ONE;
                y1_reg[ch] <= sbq_pkg::HIST_ONE;
                y2_reg[ch] <= sbq_pkg::HIST_ONE;
            end
        end
        else if (advance)
        begin
            for (int ch = 0; ch < sbq_pkg::NUM_CHAN; ch++)
            begin
                x1_reg[ch] <= sbq_pkg::HIST_BITS'(in_sample_reg[ch]);
                x2_reg[ch] <= x1_reg[ch];
                y1_reg[ch] <= sbq_pkg::HIST_BITS'(y_next[ch]);
                y2_reg[ch] <= y1_reg[ch];
            end
        end
    end

    `ASSERT_NEXT(a_adv_out_valid, advance, out_valid_reg, "advanced frame not presented")
    `ASSERT_IMPL(a_stall_only_full, in_stall, in_valid_reg, "stall with empty input register")
    `ASSERT_NEXT(a_y1_left, advance, $signed(y1_reg[0]) == $signed(left_out), "left feedback mismatch")
    `ASSERT_NEXT(a_y1_right, advance, $signed(y1_reg[1]) == $signed(right_out), "right feedback mismatch")
    `ASSERT_NEXT(a_y2_shift, advance, y2_reg[0] == $past(y1_reg[0]), "left history did not shift")

endmodule
